/* rtl/core/xyp_pkg.sv */
// Shared types and constants for the X/Y/P photon word deframer.
// Holds tag codes, the expected-tag encoding and the item/point structs.
// No dependencies.
package xyp_pkg;

	localparam int WordW = 16;
	localparam int ValW  = 13;
	localparam int TagW  = WordW - ValW;

	localparam logic [TagW-1:0] TAG_X = 3'b001;
	localparam logic [TagW-1:0] TAG_Y = 3'b010;
	localparam logic [TagW-1:0] TAG_P = 3'b011;

	typedef enum logic [1:0] {
		EXP_X = 2'd0,
		EXP_Y = 2'd1,
		EXP_P = 2'd2
	} exp_t;

	typedef struct packed {
		logic [WordW-1:0] word;
		logic             eor;
	} item_t;

	typedef struct packed {
		logic            valid;
		logic [ValW-1:0] x;
		logic [ValW-1:0] y;
		logic [ValW-1:0] p;
		logic            garbled;
	} point_t;

endpackage

/* rtl/core/xyp_in_stage.sv */
// Input register of the deframer: captures one word transfer per cycle while in_ready is high.
// Depends on xyp_pkg for the item type.
module xyp_in_stage (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  xyp_pkg::item_t in_item,
	output logic           valid_s1,
	output xyp_pkg::item_t item_s1,
	input  logic           advance
);

	logic valid_q;

	assign in_ready = !valid_q || advance;
	assign valid_s1 = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

/* rtl/core/xyp_parse_core.sv */
// Tag parser and burst state of the deframer: works out one result from the
// registered word and updates hunt/expected-tag/working/held values.
// Depends on xyp_pkg for tags, the expected-tag enum and structs.
module xyp_parse_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            advance,
	input  xyp_pkg::item_t  item_s1,
	output xyp_pkg::point_t result
);

	logic                       hunting_q, hunting_n;
	xyp_pkg::exp_t              exp_q, exp_n;
	logic [xyp_pkg::ValW-1:0]   work_x_q, work_x_n;
	logic [xyp_pkg::ValW-1:0]   work_y_q, work_y_n;
	logic [xyp_pkg::ValW-1:0]   work_p_q, work_p_n;
	logic [xyp_pkg::ValW-1:0]   held_x_q, held_x_n;
	logic [xyp_pkg::ValW-1:0]   held_y_q, held_y_n;
	logic                       had_data_q, had_data_n;
	logic [xyp_pkg::TagW-1:0]   tag;
	logic [xyp_pkg::ValW-1:0]   val;

	assign tag = item_s1.word[xyp_pkg::WordW-1:xyp_pkg::ValW];
	assign val = item_s1.word[xyp_pkg::ValW-1:0];

	always_comb begin
		hunting_n  = hunting_q;
		exp_n      = exp_q;
		work_x_n   = work_x_q;
		work_y_n   = work_y_q;
		work_p_n   = work_p_q;
		held_x_n   = held_x_q;
		held_y_n   = held_y_q;
		had_data_n = had_data_q;
		result     = '0;

		// zero words change nothing here; the end-of-burst step below still applies
		if (item_s1.word != '0) begin
			had_data_n = 1'b1;
			if (hunting_q) begin
				unique case (tag)
					xyp_pkg::TAG_X: begin
						work_x_n  = val;
						exp_n     = xyp_pkg::EXP_Y;
						hunting_n = 1'b0;
					end
					xyp_pkg::TAG_Y: begin
						// complete with the X held from the last burst
						work_x_n  = held_x_q;
						work_y_n  = val;
						exp_n     = xyp_pkg::EXP_P;
						hunting_n = 1'b0;
					end
					xyp_pkg::TAG_P: begin
						work_x_n     = held_x_q;
						work_y_n     = held_y_q;
						work_p_n     = val;
						result.valid = 1'b1;
						result.x     = held_x_q;
						result.y     = held_y_q;
						result.p     = val;
						exp_n        = xyp_pkg::EXP_X;
						hunting_n    = 1'b0;
					end
					default: result.garbled = 1'b1;
				endcase
			end else begin
				unique case (exp_q)
					xyp_pkg::EXP_Y: begin
						if (tag == xyp_pkg::TAG_Y) begin
							work_y_n = val;
							exp_n    = xyp_pkg::EXP_P;
						end else begin
							result.garbled = 1'b1;
						end
					end
					xyp_pkg::EXP_P: begin
						if (tag == xyp_pkg::TAG_P) begin
							work_p_n     = val;
							result.valid = 1'b1;
							result.x     = work_x_q;
							result.y     = work_y_q;
							result.p     = val;
							exp_n        = xyp_pkg::EXP_X;
						end else begin
							result.garbled = 1'b1;
						end
					end
					default: begin
						if (tag == xyp_pkg::TAG_X) begin
							work_x_n = val;
							exp_n    = xyp_pkg::EXP_Y;
						end else begin
							result.garbled = 1'b1;
						end
					end
				endcase
			end
		end

		// end of burst: hold X/Y if the burst saw data, then restart the hunt
		if (item_s1.eor) begin
			if (had_data_n) begin
				held_x_n = work_x_n;
				held_y_n = work_y_n;
			end
			work_x_n   = '0;
			work_y_n   = '0;
			work_p_n   = '0;
			exp_n      = xyp_pkg::EXP_X;
			hunting_n  = 1'b1;
			had_data_n = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hunting_q  <= 1'b1;
			exp_q      <= xyp_pkg::EXP_X;
			work_x_q   <= '0;
			work_y_q   <= '0;
			work_p_q   <= '0;
			held_x_q   <= '0;
			held_y_q   <= '0;
			had_data_q <= 1'b0;
		end else if (advance) begin
			hunting_q  <= hunting_n;
			exp_q      <= exp_n;
			work_x_q   <= work_x_n;
			work_y_q   <= work_y_n;
			work_p_q   <= work_p_n;
			held_x_q   <= held_x_n;
			held_y_q   <= held_y_n;
			had_data_q <= had_data_n;
		end
	end

endmodule

/* rtl/core/xyp_out_stage.sv */
// Result register of the deframer: holds one result until the sink takes it.
// Depends on xyp_pkg for the point type.
module xyp_out_stage (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  xyp_pkg::point_t result,
	output logic            load_ready,
	output logic            out_valid,
	input  logic            out_ready,
	output xyp_pkg::point_t point_s2
);

	logic valid_q;

	assign load_ready = !valid_q || out_ready;
	assign out_valid  = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load_ready) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load_ready && load) begin
			point_s2 <= result;
		end
	end

endmodule

/* rtl/core/xyp_photon_word_deframer.sv */
// X/Y/P photon word deframer, top level.
// Each word passes the input register, then the result register, on its way to the output.
// Throughput: one word per cycle while the sink is ready; the parser state
// updates as a word moves from the input register into the result register.
// Reset (arst_n low): pipeline empty, hunting set, working and held values zero.
// One result per input word; tuser flags mark a point or a garbled word.
module xyp_photon_word_deframer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // [15:0] sample_word
	input  logic        s_tlast,  // end_of_read
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // [12:0] point_x, [25:13] point_y, [38:26] point_p, [39] zero
	output logic [1:0]  m_tuser   // [0] point_valid, [1] garbled
);

	xyp_pkg::item_t  in_item;
	xyp_pkg::item_t  item_s1;
	xyp_pkg::point_t result;
	xyp_pkg::point_t point_s2;
	logic            valid_s1;
	logic            load_ready;
	logic            advance;

	assign in_item.word = s_tdata;
	assign in_item.eor  = s_tlast;
	assign advance      = valid_s1 && load_ready;

	xyp_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_item  (in_item),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.advance  (advance)
	);

	xyp_parse_core u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item_s1 (item_s1),
		.result  (result)
	);

	xyp_out_stage u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (valid_s1),
		.result     (result),
		.load_ready (load_ready),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.point_s2   (point_s2)
	);

	assign m_tdata = {1'b0, point_s2.p, point_s2.y, point_s2.x};
	assign m_tuser = {point_s2.garbled, point_s2.valid};

endmodule
